/* sv/lif_pkg.sv */
package lif_pkg;

    // Default sizing of the neuron array
    localparam int NEURONS_DEF      = 1024;
    localparam int REFRAC_STEPS_DEF = 20;

    // Configuration register indexes
    localparam logic [2:0] CFG_LEAK_GAIN      = 3'd0;
    localparam logic [2:0] CFG_VOLTAGE_OFFSET = 3'd1;
    localparam logic [2:0] CFG_EXC_GAIN       = 3'd2;
    localparam logic [2:0] CFG_INH_GAIN       = 3'd3;
    localparam logic [2:0] CFG_EXC_DECAY      = 3'd4;
    localparam logic [2:0] CFG_INH_DECAY      = 3'd5;
    localparam logic [2:0] CFG_FIRE_THRESHOLD = 3'd6;
    localparam logic [2:0] CFG_RESET_VOLTAGE  = 3'd7;

    // Stimulus select codes; any other code adds nothing
    localparam logic [1:0] MODE_SYNAPTIC = 2'd0;
    localparam logic [1:0] MODE_PRESET   = 2'd1;

    typedef struct packed {
        logic [9:0]         neuron_index;
        logic signed [31:0] syn_exc;
        logic signed [31:0] syn_inh;
        logic signed [31:0] preset_value;
        logic [1:0]         input_mode;
    } item_t;

    typedef struct packed {
        logic [9:0]         out_neuron;
        logic               fired;
        logic signed [31:0] voltage_out;
    } result_t;

    // Per-neuron state word held in the state RAM
    typedef struct packed {
        logic signed [31:0] voltage;
        logic signed [31:0] exc;
        logic signed [31:0] inh;
        logic [15:0]        refr;
        logic [31:0]        spikes;
    } nstate_t;

endpackage

/* sv/lif_ram.sv */
module lif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; old data on a read-during-write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/lif_neuron_update.sv */
// A result passes the RAM read, multiply and update registers after its item transfers.
// Throughput: one item per cycle unless clearing or held by result_stall; an item for the same
// neuron as the one before it waits for that one to leave stage 1 (state RAM read-modify-write).
// Reset: configuration registers clear to zero, then a clearing pass writes zero state to
// all NEURONS entries, one per cycle; items stall until the pass is done.
module lif_neuron_update #(
    parameter int NEURONS      = lif_pkg::NEURONS_DEF,
    parameter int REFRAC_STEPS = lif_pkg::REFRAC_STEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic            item_valid,
    output logic            item_stall,
    input  lif_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output lif_pkg::result_t result
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int SW = $bits(lif_pkg::nstate_t);
    localparam logic [15:0] REFRAC_LOAD = 16'(REFRAC_STEPS - 1);

    // Saturate a wide signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [31:0] r;
        if (x[49:31] != {19{x[49]}})
        begin
            r = x[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic signed [31:0] leak_gain_reg;
    logic signed [31:0] voltage_offset_reg;
    logic signed [31:0] exc_gain_reg;
    logic signed [31:0] inh_gain_reg;
    logic signed [31:0] exc_decay_reg;
    logic signed [31:0] inh_decay_reg;
    logic signed [31:0] fire_threshold_reg;
    logic signed [31:0] reset_voltage_reg;

    // Clearing pass
    logic          clear_busy_reg;
    logic [AW-1:0] clear_addr_reg;

    // Pipeline control and payload
    logic             adv;
    logic             accept;
    logic             hazard;
    logic [AW-1:0]    in_addr;
    logic             in_range;

    logic             s1_valid_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_in_range_reg;
    lif_pkg::item_t   s1_item_reg;
    logic             byp_hit_reg;
    lif_pkg::nstate_t byp_data_reg;
    lif_pkg::nstate_t s1_state;
    logic [SW-1:0]    ram_rd_data;

    logic               s2_valid_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic               s2_in_range_reg;
    lif_pkg::item_t     s2_item_reg;
    lif_pkg::nstate_t   s2_state_reg;
    logic signed [47:0] p_leak_reg;
    logic signed [47:0] p_egain_reg;
    logic signed [47:0] p_igain_reg;
    logic signed [47:0] p_edecay_reg;
    logic signed [47:0] p_idecay_reg;

    logic signed [63:0] p_leak;
    logic signed [63:0] p_egain;
    logic signed [63:0] p_igain;
    logic signed [63:0] p_edecay;
    logic signed [63:0] p_idecay;

    logic signed [49:0] v_sum;
    logic signed [31:0] v_new;
    logic signed [31:0] e_dec;
    logic signed [31:0] i_dec;
    logic signed [31:0] stim_e;
    logic signed [31:0] stim_i;
    logic signed [31:0] e_stim;
    logic signed [31:0] i_stim;
    logic               spike;
    lif_pkg::nstate_t   s2_next_state;
    lif_pkg::result_t   s2_result;
    logic               s2_wr;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    lif_pkg::nstate_t   ram_wdata;

    logic               result_valid_reg;
    lif_pkg::result_t   result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_gain_reg      <= '0;
            voltage_offset_reg <= '0;
            exc_gain_reg       <= '0;
            inh_gain_reg       <= '0;
            exc_decay_reg      <= '0;
            inh_decay_reg      <= '0;
            fire_threshold_reg <= '0;
            reset_voltage_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lif_pkg::CFG_LEAK_GAIN:      leak_gain_reg      <= cfg_data;
                lif_pkg::CFG_VOLTAGE_OFFSET: voltage_offset_reg <= cfg_data;
                lif_pkg::CFG_EXC_GAIN:       exc_gain_reg       <= cfg_data;
                lif_pkg::CFG_INH_GAIN:       inh_gain_reg       <= cfg_data;
                lif_pkg::CFG_EXC_DECAY:      exc_decay_reg      <= cfg_data;
                lif_pkg::CFG_INH_DECAY:      inh_decay_reg      <= cfg_data;
                lif_pkg::CFG_FIRE_THRESHOLD: fire_threshold_reg <= cfg_data;
                lif_pkg::CFG_RESET_VOLTAGE:  reset_voltage_reg  <= cfg_data;
                default:                     leak_gain_reg      <= leak_gain_reg;
            endcase
        end
    end

    // Sweep the state RAM to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            if (clear_addr_reg == AW'(NEURONS - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + AW'(1);
        end
    end

    // Input side: stall while clearing, while the pipe holds, or right behind the same neuron
    assign adv      = !result_valid_reg || !result_stall;
    assign in_addr  = AW'(item.neuron_index);
    assign in_range = 32'(item.neuron_index) < 32'(NEURONS);
    assign hazard   = s1_valid_reg && (s1_addr_reg == in_addr);
    assign item_stall = clear_busy_reg || !adv || hazard;
    assign accept     = item_valid && !item_stall;

    // State RAM write port: clearing pass or update write-back
    assign s2_wr     = s2_valid_reg && s2_in_range_reg && adv;
    assign ram_we    = clear_busy_reg || s2_wr;
    assign ram_waddr = clear_busy_reg ? clear_addr_reg : s2_addr_reg;
    assign ram_wdata = clear_busy_reg ? '0 : s2_next_state;

    lif_ram #(
        .WIDTH (SW),
        .DEPTH (NEURONS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (ram_rd_data)
    );

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= accept;
            end
            if (accept)
            begin
                byp_hit_reg <= s2_wr && (s2_addr_reg == in_addr);
            end
        end
    end

    // Stage 1 payload; capture a write-back that collides with this read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_item_reg     <= item;
            byp_data_reg    <= s2_next_state;
        end
    end

    // Stage 1: forward, then multiply
    assign s1_state = byp_hit_reg ? byp_data_reg : lif_pkg::nstate_t'(ram_rd_data);
    assign p_leak   = leak_gain_reg * s1_state.voltage;
    assign p_egain  = s1_state.exc * exc_gain_reg;
    assign p_igain  = s1_state.inh * inh_gain_reg;
    assign p_edecay = s1_state.exc * exc_decay_reg;
    assign p_idecay = s1_state.inh * inh_decay_reg;

    // Stage 2 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 2 payload; products floored by dropping 16 fraction bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_addr_reg     <= s1_addr_reg;
            s2_in_range_reg <= s1_in_range_reg;
            s2_item_reg     <= s1_item_reg;
            s2_state_reg    <= s1_state;
            p_leak_reg      <= p_leak[63:16];
            p_egain_reg     <= p_egain[63:16];
            p_igain_reg     <= p_igain[63:16];
            p_edecay_reg    <= p_edecay[63:16];
            p_idecay_reg    <= p_idecay[63:16];
        end
    end

    // Stage 2: integrate, decay, threshold and stimulus
    always_comb
    begin
        v_sum = 50'(p_leak_reg) + 50'(voltage_offset_reg)
              + 50'(p_egain_reg) + 50'(p_igain_reg);
        v_new = sat32(v_sum);
        e_dec = sat32(50'(p_edecay_reg));
        i_dec = sat32(50'(p_idecay_reg));
        spike = v_new >= fire_threshold_reg;

        case (s2_item_reg.input_mode)
            lif_pkg::MODE_SYNAPTIC:
            begin
                stim_e = s2_item_reg.syn_exc;
                stim_i = s2_item_reg.syn_inh;
            end
            lif_pkg::MODE_PRESET:
            begin
                stim_e = s2_item_reg.preset_value;
                stim_i = s2_item_reg.preset_value;
            end
            default:
            begin
                stim_e = '0;
                stim_i = '0;
            end
        endcase
        e_stim = sat32(50'(e_dec) + 50'(stim_e));
        i_stim = sat32(50'(i_dec) + 50'(stim_i));

        s2_next_state = s2_state_reg;
        s2_result.out_neuron  = s2_item_reg.neuron_index;
        s2_result.fired       = 1'b0;
        s2_result.voltage_out = '0;

        if (s2_state_reg.refr != 16'd0)
        begin
            // Refractory: count down only
            s2_next_state.refr = s2_state_reg.refr - 16'd1;
        end
        else if (spike)
        begin
            s2_next_state.voltage = reset_voltage_reg;
            s2_next_state.exc     = e_dec;
            s2_next_state.inh     = i_dec;
            s2_next_state.refr    = REFRAC_LOAD;
            s2_next_state.spikes  = (s2_state_reg.spikes == '1) ? s2_state_reg.spikes
                                                                 : s2_state_reg.spikes + 32'd1;
            s2_result.fired       = 1'b1;
        end
        else
        begin
            s2_next_state.voltage = v_new;
            s2_next_state.exc     = e_stim;
            s2_next_state.inh     = i_stim;
        end

        // Out-of-range index reports zero voltage and no spike
        if (s2_in_range_reg)
        begin
            s2_result.voltage_out = s2_next_state.voltage;
        end
        else
        begin
            s2_result.fired = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= s2_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* dv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEURONS      = lif_pkg::NEURONS_DEF;
    localparam int REFRAC_STEPS = lif_pkg::REFRAC_STEPS_DEF;
    localparam int NUM_CFG      = int'(lif_pkg::CFG_RESET_VOLTAGE) + 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 40;

    // Stimulus codes with no package name: both add nothing to the currents
    localparam logic [1:0] MODE_NONE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [31:0]      cfg_data = '0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    lif_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    lif_pkg::result_t result;

    // Predicted neuron state and register copy
    logic signed [31:0] cfg_reg [NUM_CFG];
    logic signed [31:0] cfg_plan [NUM_CFG];
    logic signed [31:0] mem_v [NEURONS];
    logic signed [31:0] cur_exc [NEURONS];
    logic signed [31:0] cur_inh [NEURONS];
    logic [15:0]        refr_left [NEURONS];
    logic [31:0]        spike_cnt [NEURONS];

    lif_pkg::item_t   items_to_send [$];
    lif_pkg::result_t results_due [$];

    int items_queued = 0;
    int items_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int cycle_count = 0;
    int spike_events = 0;
    int refr_steps = 0;
    int settings_used = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    lif_neuron_update i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    // Q16.16 product, floored, before saturation
    function automatic longint q_product(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > longint'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (x < longint'(32'sh80000000))
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // Advance one neuron by one time step and return the update it reports
    function automatic lif_pkg::result_t step_neuron(lif_pkg::item_t it);
        lif_pkg::result_t   r;
        longint             acc;
        logic signed [31:0] v;
        logic signed [31:0] e;
        logic signed [31:0] inh;
        logic signed [31:0] nv;
        logic signed [31:0] se;
        logic signed [31:0] si;
        logic signed [31:0] pv;
        int                 n;
        n = int'(it.neuron_index);
        se = it.syn_exc;
        si = it.syn_inh;
        pv = it.preset_value;
        r.out_neuron = it.neuron_index;
        r.fired = 1'b0;
        r.voltage_out = '0;
        if (n < NEURONS) begin
            if (refr_left[n] == 0) begin
                v = mem_v[n];
                e = cur_exc[n];
                inh = cur_inh[n];
                acc = q_product(cfg_reg[lif_pkg::CFG_LEAK_GAIN], v)
                    + longint'(cfg_reg[lif_pkg::CFG_VOLTAGE_OFFSET])
                    + q_product(e, cfg_reg[lif_pkg::CFG_EXC_GAIN])
                    + q_product(inh, cfg_reg[lif_pkg::CFG_INH_GAIN]);
                nv = clamp32(acc);
                e = clamp32(q_product(e, cfg_reg[lif_pkg::CFG_EXC_DECAY]));
                inh = clamp32(q_product(inh, cfg_reg[lif_pkg::CFG_INH_DECAY]));
                if (nv >= cfg_reg[lif_pkg::CFG_FIRE_THRESHOLD]) begin
                    r.fired = 1'b1;
                    spike_events++;
                    if (spike_cnt[n] != 32'hFFFFFFFF)
                        spike_cnt[n]++;
                    refr_left[n] = 16'(REFRAC_STEPS - 1);
                    nv = cfg_reg[lif_pkg::CFG_RESET_VOLTAGE];
                end else if (it.input_mode == lif_pkg::MODE_SYNAPTIC) begin
                    e = clamp32(longint'(e) + longint'(se));
                    inh = clamp32(longint'(inh) + longint'(si));
                end else if (it.input_mode == lif_pkg::MODE_PRESET) begin
                    e = clamp32(longint'(e) + longint'(pv));
                    inh = clamp32(longint'(inh) + longint'(pv));
                end
                mem_v[n] = nv;
                cur_exc[n] = e;
                cur_inh[n] = inh;
            end else begin
                refr_left[n]--;
                refr_steps++;
            end
            r.voltage_out = mem_v[n];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] rand_stim();
        case ($urandom_range(7))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $urandom_range(32'h40000) - 32'h10000;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic queue_item(input logic [9:0] idx, input logic signed [31:0] se,
                              input logic signed [31:0] si, input logic signed [31:0] pv,
                              input logic [1:0] mode);
        lif_pkg::item_t it;
        it.neuron_index = idx;
        it.syn_exc = se;
        it.syn_inh = si;
        it.preset_value = pv;
        it.input_mode = mode;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    // Write all registers; no items are in flight whenever this runs
    task automatic apply_config();
        for (int k = 0; k < NUM_CFG; k++) begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= 3'(k);
            cfg_data <= cfg_plan[k];
            cfg_reg[k] = cfg_plan[k];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        while (items_sent != items_queued || results_seen != items_queued)
            @(posedge clk);
    endtask

    // Offer queued items; hold the payload until the transfer completes
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            item <= '0;
        end else begin
            if (item_valid && !item_stall) begin
                results_due.push_back(step_neuron(item));
                items_sent++;
            end
            if (!item_valid || !item_stall) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_valid <= 1'b1;
                    item <= items_to_send.pop_front();
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Drive result stall; hold off once for a long stretch to back up the block
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            result_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end else begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check each result transfer against the oldest predicted update
    always @(posedge clk) begin : watch_results
        lif_pkg::result_t want;
        if (rst_n && result_valid && !result_stall) begin
            results_seen++;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result for neuron %0d",
                                          result.out_neuron));
            end else begin
                want = results_due.pop_front();
                if (result.out_neuron !== want.out_neuron)
                    report_mismatch($sformatf("out_neuron %0d, expected %0d",
                                              result.out_neuron, want.out_neuron));
                if (result.fired !== want.fired)
                    report_mismatch($sformatf("neuron %0d fired %b, expected %b",
                                              want.out_neuron, result.fired, want.fired));
                if (result.voltage_out !== want.voltage_out)
                    report_mismatch($sformatf("neuron %0d voltage_out %h, expected %h",
                                              want.out_neuron, result.voltage_out,
                                              want.voltage_out));
            end
        end
    end

    // Guard against a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    initial begin
        int         n_items;
        int         hot_base;
        int         pick;
        logic [1:0] mode;
        logic [9:0] idx;

        for (int k = 0; k < NEURONS; k++) begin
            mem_v[k] = '0;
            cur_exc[k] = '0;
            cur_inh[k] = '0;
            refr_left[k] = '0;
            spike_cnt[k] = '0;
        end
        for (int k = 0; k < NUM_CFG; k++)
            cfg_reg[k] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, every mode, a spike and the full countdown
        send_idle_pct = 14;
        recv_idle_pct = 59;
        cfg_plan[lif_pkg::CFG_LEAK_GAIN]      = 32'sh00008000;
        cfg_plan[lif_pkg::CFG_VOLTAGE_OFFSET] = 32'sh00010000;
        cfg_plan[lif_pkg::CFG_EXC_GAIN]       = 32'sh00010000;
        cfg_plan[lif_pkg::CFG_INH_GAIN]       = 32'shFFFF0000;
        cfg_plan[lif_pkg::CFG_EXC_DECAY]      = 32'sh00008000;
        cfg_plan[lif_pkg::CFG_INH_DECAY]      = 32'sh00008000;
        cfg_plan[lif_pkg::CFG_FIRE_THRESHOLD] = 32'sh00040000;
        cfg_plan[lif_pkg::CFG_RESET_VOLTAGE]  = 32'shFFFF0000;
        apply_config();
        queue_item(10'd0, '0, '0, '0, MODE_NONE);
        queue_item(10'd1023, 32'sh7FFFFFFF, 32'sh80000000, '0, lif_pkg::MODE_SYNAPTIC);
        queue_item(10'd1023, '0, '0, '0, MODE_NONE);
        for (int k = 0; k < REFRAC_STEPS; k++)
            queue_item(10'd1023, 32'sh00010000, 32'sh00010000, 32'sh7FFFFFFF, 2'(k));
        queue_item(10'd5, '0, '0, 32'sh7FFFFFFF, lif_pkg::MODE_PRESET);
        queue_item(10'd5, '0, '0, 32'sh80000000, lif_pkg::MODE_PRESET);
        queue_item(10'd0, 32'sh80000000, 32'sh7FFFFFFF, '0, lif_pkg::MODE_SYNAPTIC);
        queue_item(10'd0, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, MODE_SPARE);
        wait_drained();

        // Random part: extreme and all-zero settings first, then typical ones with stray values
        for (int ph = 1; ph <= 6; ph++) begin
            if (ph <= 2) begin
                send_idle_pct = 14;
                recv_idle_pct = 59;
            end else if (ph <= 4) begin
                send_idle_pct = 59;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: for (int k = 0; k < NUM_CFG; k++) cfg_plan[k] = 32'sh7FFFFFFF;
                2: for (int k = 0; k < NUM_CFG; k++) cfg_plan[k] = 32'sh80000000;
                3: for (int k = 0; k < NUM_CFG; k++) cfg_plan[k] = '0;
                default: begin
                    cfg_plan[lif_pkg::CFG_LEAK_GAIN] = $urandom_range(32'h10000);
                    cfg_plan[lif_pkg::CFG_VOLTAGE_OFFSET] =
                        $urandom_range(32'h20000) - 32'h10000;
                    cfg_plan[lif_pkg::CFG_EXC_GAIN] = $urandom_range(32'h18000, 32'h8000);
                    cfg_plan[lif_pkg::CFG_INH_GAIN] =
                        32'h0 - $urandom_range(32'h18000, 32'h8000);
                    cfg_plan[lif_pkg::CFG_EXC_DECAY] = $urandom_range(32'hF000, 32'h4000);
                    cfg_plan[lif_pkg::CFG_INH_DECAY] = $urandom_range(32'hF000, 32'h4000);
                    cfg_plan[lif_pkg::CFG_FIRE_THRESHOLD] =
                        $urandom_range(32'h80000, 32'h10000);
                    cfg_plan[lif_pkg::CFG_RESET_VOLTAGE] =
                        $urandom_range(32'h20000) - 32'h10000;
                    for (int k = 0; k < NUM_CFG; k++)
                        if ($urandom_range(7) == 0)
                            cfg_plan[k] = $urandom();
                end
            endcase
            apply_config();

            // Keep most updates on a few neurons so they spike and go refractory
            n_items = (ph <= 3) ? 100 : 370;
            hot_base = $urandom_range(NEURONS - 8);
            for (int k = 0; k < n_items; k++) begin
                pick = $urandom_range(9);
                if (pick < 5)
                    mode = lif_pkg::MODE_SYNAPTIC;
                else if (pick < 8)
                    mode = lif_pkg::MODE_PRESET;
                else if (pick == 8)
                    mode = MODE_NONE;
                else
                    mode = MODE_SPARE;
                if ($urandom_range(3) != 0)
                    idx = 10'(hot_base + $urandom_range(7));
                else
                    idx = 10'($urandom_range(NEURONS - 1));
                queue_item(idx, rand_stim(), rand_stim(), rand_stim(), mode);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("covered %0d neuron updates under %0d register settings",
                 results_seen, settings_used);
        $display("saw %0d spikes and %0d refractory steps, %0d mismatches",
                 spike_events, refr_steps, errors);
        if (errors == 0 && results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
